FILE: hw/rtl/qrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qrs_pkg;

	localparam int CoefW = 16;
	// discriminant B*B - 4*A*C, signed
	localparam int DiscW = 34;
	// radicand D * 2^16, padded to an even width
	localparam int RadW  = 50;
	localparam int SqW   = RadW / 2;
	// signed numerator -B*256 +/- S
	localparam int NumW  = 28;
	// magnitude of the numerator times 256
	localparam int DvdW  = NumW - 1 + 8;
	// magnitude of 2*A
	localparam int DenW  = CoefW + 1;
	// signed quotient before clipping
	localparam int QsW   = DvdW + 1;
	localparam int Lat   = 2 + SqW + 1 + DvdW + 1;

	localparam logic [1:0] CountNone = 2'd0;
	localparam logic [1:0] CountOne  = 2'd1;
	localparam logic [1:0] CountTwo  = 2'd2;

	typedef struct packed {
		logic signed [CoefW-1:0] a;
		logic signed [CoefW-1:0] b;
		logic                    deg;
		logic                    neg;
		logic                    zero;
	} sq_side_t;

	typedef struct packed {
		logic sgn_p;
		logic sgn_m;
		logic deg;
		logic neg;
		logic zero;
	} div_side_t;

endpackage

`default_nettype wire

FILE: hw/rtl/qrs_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module qrs_isqrt #(
	parameter int SideW = 1
) (
	input  wire logic                         clk,
	input  wire logic                         en,
	input  wire logic [qrs_pkg::RadW-1:0]     rad,
	input  wire logic [SideW-1:0]             side_in,
	output logic      [qrs_pkg::SqW-1:0]      root,
	output logic      [SideW-1:0]             side_out
);

	localparam int RW = qrs_pkg::RadW;
	localparam int SW = qrs_pkg::SqW;

	logic [RW-1:0]    rad_s  [1:SW];
	logic [SW:0]      rem_s  [1:SW];
	logic [SW-1:0]    root_s [1:SW];
	logic [SideW-1:0] side_s [1:SW];

	for (genvar k = 0; k < SW; k++) begin : g_stage
		logic [RW-1:0]    rad_i;
		logic [SW:0]      rem_i;
		logic [SW-1:0]    root_i;
		logic [SideW-1:0] side_i;
		logic [SW+1:0]    cur;
		logic [SW+1:0]    trial;
		logic [SW+1:0]    diff;
		logic             ge;

		if (k == 0) begin : g_first
			assign rad_i  = rad;
			assign rem_i  = '0;
			assign root_i = '0;
			assign side_i = side_in;
		end else begin : g_next
			assign rad_i  = rad_s[k];
			assign rem_i  = rem_s[k];
			assign root_i = root_s[k];
			assign side_i = side_s[k];
		end

		// bring down the next two radicand bits and try 4*root + 1
		assign cur   = {rem_i[SW-1:0], rad_i[RW-1 -: 2]};
		assign trial = {1'b0, root_i[SW-2:0], 2'b01};
		assign diff  = cur - trial;
		assign ge    = cur >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1]  <= {rad_i[RW-3:0], 2'b00};
				rem_s[k+1]  <= ge ? diff[SW:0] : cur[SW:0];
				root_s[k+1] <= {root_i[SW-2:0], ge};
				side_s[k+1] <= side_i;
			end
		end
	end

	assign root     = root_s[SW];
	assign side_out = side_s[SW];

endmodule

`default_nettype wire

FILE: hw/rtl/qrs_div.sv
`timescale 1ns / 1ps
`default_nettype none

module qrs_div #(
	parameter int SideW = 1
) (
	input  wire logic                         clk,
	input  wire logic                         en,
	input  wire logic [qrs_pkg::DvdW-1:0]     dvd_p,
	input  wire logic [qrs_pkg::DvdW-1:0]     dvd_m,
	input  wire logic [qrs_pkg::DenW-1:0]     den,
	input  wire logic [SideW-1:0]             side_in,
	output logic      [qrs_pkg::DvdW-1:0]     quo_p,
	output logic      [qrs_pkg::DvdW-1:0]     quo_m,
	output logic      [SideW-1:0]             side_out
);

	localparam int NW = qrs_pkg::DvdW;
	localparam int DW = qrs_pkg::DenW;

	// dividend shifts out at the top while quotient bits shift in below
	logic [NW-1:0]    dq_p_s  [1:NW];
	logic [NW-1:0]    dq_m_s  [1:NW];
	logic [DW-1:0]    rem_p_s [1:NW];
	logic [DW-1:0]    rem_m_s [1:NW];
	logic [DW-1:0]    den_s   [1:NW];
	logic [SideW-1:0] side_s  [1:NW];

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [NW-1:0]    dq_p_i, dq_m_i;
		logic [DW-1:0]    rem_p_i, rem_m_i, den_i;
		logic [SideW-1:0] side_i;
		logic [DW:0]      cur_p, cur_m, dif_p, dif_m;
		logic             ge_p, ge_m;

		if (k == 0) begin : g_first
			assign dq_p_i  = dvd_p;
			assign dq_m_i  = dvd_m;
			assign rem_p_i = '0;
			assign rem_m_i = '0;
			assign den_i   = den;
			assign side_i  = side_in;
		end else begin : g_next
			assign dq_p_i  = dq_p_s[k];
			assign dq_m_i  = dq_m_s[k];
			assign rem_p_i = rem_p_s[k];
			assign rem_m_i = rem_m_s[k];
			assign den_i   = den_s[k];
			assign side_i  = side_s[k];
		end

		assign cur_p = {rem_p_i, dq_p_i[NW-1]};
		assign cur_m = {rem_m_i, dq_m_i[NW-1]};
		assign dif_p = cur_p - {1'b0, den_i};
		assign dif_m = cur_m - {1'b0, den_i};
		assign ge_p  = cur_p >= {1'b0, den_i};
		assign ge_m  = cur_m >= {1'b0, den_i};

		always_ff @(posedge clk) begin
			if (en) begin
				dq_p_s[k+1]  <= {dq_p_i[NW-2:0], ge_p};
				dq_m_s[k+1]  <= {dq_m_i[NW-2:0], ge_m};
				rem_p_s[k+1] <= ge_p ? dif_p[DW-1:0] : cur_p[DW-1:0];
				rem_m_s[k+1] <= ge_m ? dif_m[DW-1:0] : cur_m[DW-1:0];
				den_s[k+1]   <= den_i;
				side_s[k+1]  <= side_i;
			end
		end
	end

	assign quo_p    = dq_p_s[NW];
	assign quo_m    = dq_m_s[NW];
	assign side_out = side_s[NW];

endmodule

`default_nettype wire

FILE: hw/rtl/quadratic_root_solver_unit.sv
// An item passes the product and discriminant registers, the square root (one result
// bit per stage, 25 stages), the divider input register, the two dividers (one quotient
// bit per stage, 35 stages) and the output register. Throughput: one item per cycle;
// the whole pipeline advances together and halts while a result waits under stall.
// Reset (arst_n low, asynchronous) clears all valid bits; no result is pending after it.
`timescale 1ns / 1ps
`default_nettype none

module quadratic_root_solver_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               coef_valid,
	output logic                    coef_stall,
	input  wire logic signed [15:0] coef_quad,
	input  wire logic signed [15:0] coef_lin,
	input  wire logic signed [15:0] coef_const,
	output logic                    root_valid,
	input  wire logic               root_stall,
	output logic             [1:0]  root_count,
	output logic signed      [31:0] root_plus,
	output logic signed      [31:0] root_minus,
	output logic                    degenerate,
	output logic                    saturated
);

	localparam int Lat = qrs_pkg::Lat;
	localparam int SqSideW  = $bits(qrs_pkg::sq_side_t);
	localparam int DivSideW = $bits(qrs_pkg::div_side_t);

	logic           en;
	logic [Lat-1:0] vld_q;

	assign root_valid = vld_q[Lat-1];
	assign en         = !(root_valid && root_stall);
	assign coef_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[Lat-2:0], coef_valid};
		end
	end

	// products
	logic signed [15:0] a_s1, b_s1;
	logic signed [31:0] bb_s1, ac_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= coef_quad;
			b_s1  <= coef_lin;
			bb_s1 <= coef_lin * coef_lin;
			ac_s1 <= coef_quad * coef_const;
		end
	end

	// discriminant
	logic signed [15:0] a_s2, b_s2;
	logic signed [qrs_pkg::DiscW-1:0] d_s2;
	logic deg_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2   <= a_s1;
			b_s2   <= b_s1;
			deg_s2 <= a_s1 == '0;
			d_s2   <= qrs_pkg::DiscW'(bb_s1) - (qrs_pkg::DiscW'(ac_s1) <<< 2);
		end
	end

	qrs_pkg::sq_side_t              sq_in, sq_out;
	logic [qrs_pkg::RadW-1:0]       rad;
	logic [qrs_pkg::SqW-1:0]        sq_root;
	logic [SqSideW-1:0]             sq_side_vec;

	assign sq_in.a    = a_s2;
	assign sq_in.b    = b_s2;
	assign sq_in.deg  = deg_s2;
	assign sq_in.neg  = d_s2[qrs_pkg::DiscW-1];
	assign sq_in.zero = d_s2 == '0;
	// a negative discriminant feeds zero; its roots are dropped at the end
	assign rad = d_s2[qrs_pkg::DiscW-1] ? '0
		: {1'b0, d_s2[qrs_pkg::DiscW-2:0], 16'h0000};

	qrs_isqrt #(.SideW(SqSideW)) u_isqrt (
		.clk     (clk),
		.en      (en),
		.rad     (rad),
		.side_in (sq_in),
		.root    (sq_root),
		.side_out(sq_side_vec)
	);

	assign sq_out = sq_side_vec;

	// numerators and divisor magnitude
	logic signed [qrs_pkg::NumW-1:0] bx, sx, np, nm, mp, mm;
	logic [15:0] absa;

	assign bx   = qrs_pkg::NumW'(sq_out.b) <<< 8;
	assign sx   = {3'b000, sq_root};
	assign np   = sx - bx;
	assign nm   = -sx - bx;
	assign mp   = np[qrs_pkg::NumW-1] ? -np : np;
	assign mm   = nm[qrs_pkg::NumW-1] ? -nm : nm;
	assign absa = sq_out.a[15] ? 16'(-sq_out.a) : 16'(sq_out.a);

	logic [qrs_pkg::DvdW-1:0] dvd_p_s3, dvd_m_s3;
	logic [qrs_pkg::DenW-1:0] den_s3;
	qrs_pkg::div_side_t       dv_s3, dv_out;
	logic [DivSideW-1:0]      dv_side_vec;

	always_ff @(posedge clk) begin
		if (en) begin
			dvd_p_s3    <= {mp[qrs_pkg::NumW-2:0], 8'h00};
			dvd_m_s3    <= {mm[qrs_pkg::NumW-2:0], 8'h00};
			den_s3      <= {absa, 1'b0};
			dv_s3.sgn_p <= np[qrs_pkg::NumW-1] ^ sq_out.a[15];
			dv_s3.sgn_m <= nm[qrs_pkg::NumW-1] ^ sq_out.a[15];
			dv_s3.deg   <= sq_out.deg;
			dv_s3.neg   <= sq_out.neg;
			dv_s3.zero  <= sq_out.zero;
		end
	end

	logic [qrs_pkg::DvdW-1:0] quo_p, quo_m;

	qrs_div #(.SideW(DivSideW)) u_div (
		.clk     (clk),
		.en      (en),
		.dvd_p   (dvd_p_s3),
		.dvd_m   (dvd_m_s3),
		.den     (den_s3),
		.side_in (dv_s3),
		.quo_p   (quo_p),
		.quo_m   (quo_m),
		.side_out(dv_side_vec)
	);

	assign dv_out = dv_side_vec;

	// apply sign and clip to 32 bits; top bit of the result flags a clip
	function automatic logic [32:0] clip(input logic [qrs_pkg::DvdW-1:0] q, input logic sgn);
		logic signed [qrs_pkg::QsW-1:0] ext;
		logic signed [qrs_pkg::QsW-1:0] v;
		logic [32:0] r;
		ext = {1'b0, q};
		v   = sgn ? -ext : ext;
		if (v > qrs_pkg::QsW'(64'sd2147483647)) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (v < qrs_pkg::QsW'(-64'sd2147483648)) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

	logic [32:0] cp, cm;

	assign cp = clip(quo_p, dv_out.sgn_p);
	assign cm = clip(quo_m, dv_out.sgn_m);

	always_ff @(posedge clk) begin
		if (en) begin
			if (dv_out.deg) begin
				root_count <= qrs_pkg::CountNone;
				root_plus  <= '0;
				root_minus <= '0;
				degenerate <= 1'b1;
				saturated  <= 1'b0;
			end else if (dv_out.neg) begin
				root_count <= qrs_pkg::CountNone;
				root_plus  <= '0;
				root_minus <= '0;
				degenerate <= 1'b0;
				saturated  <= 1'b0;
			end else begin
				root_count <= dv_out.zero ? qrs_pkg::CountOne : qrs_pkg::CountTwo;
				root_plus  <= cp[31:0];
				root_minus <= cm[31:0];
				degenerate <= 1'b0;
				saturated  <= cp[32] | cm[32];
			end
		end
	end

endmodule

`default_nettype wire
